[design/svp_pkg.sv]
`default_nettype none

package svp_pkg;

    // item kinds carried in the mode field
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_CTRL = 1'b1;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_FRAME_TICKS  = 3'd0,
        CFG_WIDTH_MIN    = 3'd1,
        CFG_WIDTH_MAX    = 3'd2,
        CFG_WIDTH_STEP   = 3'd3,
        CFG_WIDTH_CENTER = 3'd4
    } svp_cfg_idx_t;

    localparam int unsigned CFG_DATA_W = 16;

    // register reset values
    localparam logic [15:0] FRAME_TICKS_RST  = 16'd18432;
    localparam logic [11:0] WIDTH_MIN_RST    = 12'd500;
    localparam logic [11:0] WIDTH_MAX_RST    = 12'd2500;
    localparam logic [7:0]  WIDTH_STEP_RST   = 8'd100;
    localparam logic [11:0] WIDTH_CENTER_RST = 12'd1500;
    localparam logic [15:0] HIGH_TICKS_RST   = 16'd461;

    // target = 500 + floor(2000 * adc / 255), as adc * 2000 * ceil(2^27 / 255) >> 27
    localparam logic [11:0] TGT_BASE   = 12'd500;
    localparam logic [30:0] TGT_RECIP  = 31'd1052690000;
    localparam int unsigned TGT_SHIFT  = 27;

    // counts = floor(width * 576 / 625), as width * 576 * ceil(2^30 / 625) >> 30
    localparam logic [29:0] TICK_RECIP = 30'd989560512;
    localparam int unsigned TICK_SHIFT = 30;

    // decimal split of a 12 bit width by reciprocal multiplication
    localparam logic [11:0] DIV10_RECIP   = 12'd3277;
    localparam int unsigned DIV10_SHIFT   = 15;
    localparam logic [10:0] DIV100_RECIP  = 11'd1311;
    localparam int unsigned DIV100_SHIFT  = 17;
    localparam logic [12:0] DIV1000_RECIP = 13'd4195;
    localparam int unsigned DIV1000_SHIFT = 22;

    localparam logic [11:0] WIDTH_SAT = 12'd4095;

    typedef struct packed {
        logic       mode;
        logic [7:0] adc_sample;
        logic       step_up;
        logic       step_down;
        logic       center;
    } svp_in_t;

    typedef struct packed {
        logic        pwm_level;
        logic [11:0] pulse_width_us;
        logic [2:0]  digit_thousands;
        logic [3:0]  digit_hundreds;
        logic [3:0]  digit_tens;
        logic [3:0]  digit_units;
    } svp_out_t;

endpackage

`default_nettype wire

[design/servo_pulse_setpoint_and_pwm.sv]
`default_nettype none

// Servo pulse generator with setpoint control. Every accepted item gives exactly one result:
// a timer tick item advances the pulse train by one count and reports the level of that count,
// a control item retargets the width when the converter reading gives a new target, applies the up,
// down and center presses and reports the present level. Results also carry the width and its four
// decimal digits. The block takes one item per clock unless the pipeline is backed up, and each
// result passes the input register, state update, reciprocal multiply and digit fix-up; the rate
// is set by the state update, which lets a new item follow in every cycle. Stages whose
// downstream neighbor is empty keep moving while a finished result waits, so only a fully
// backed-up pipeline stalls s_ready. Configuration is written through cfg_wr_en / cfg_index /
// cfg_wdata with no wait state and must only change while the block is idle; a new frame_ticks
// applies from the next low phase, a width change from the next latch at the end of a high phase.
// There is no clearing pass after reset.
module servo_pulse_setpoint_and_pwm
    import svp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire svp_in_t               s_data,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output svp_out_t                   m_data,

    input  wire logic                  cfg_wr_en,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [15:0] frame_ticks_reg;
    logic [11:0] width_min_reg;
    logic [11:0] width_max_reg;
    logic [7:0]  width_step_reg;
    logic [11:0] width_center_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_ticks_reg  <= FRAME_TICKS_RST;
            width_min_reg    <= WIDTH_MIN_RST;
            width_max_reg    <= WIDTH_MAX_RST;
            width_step_reg   <= WIDTH_STEP_RST;
            width_center_reg <= WIDTH_CENTER_RST;
        end else if (cfg_wr_en) begin
            unique case (svp_cfg_idx_t'(cfg_index))
                CFG_FRAME_TICKS:  frame_ticks_reg  <= cfg_wdata;
                CFG_WIDTH_MIN:    width_min_reg    <= cfg_wdata[11:0];
                CFG_WIDTH_MAX:    width_max_reg    <= cfg_wdata[11:0];
                CFG_WIDTH_STEP:   width_step_reg   <= cfg_wdata[7:0];
                CFG_WIDTH_CENTER: width_center_reg <= cfg_wdata[11:0];
                default: ;  // unused indexes are ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage handshake: each stage moves when its successor is empty or moving
    // ------------------------------------------------------------------
    logic in_vld_reg;
    logic st_vld_reg;
    logic dg_vld_reg;
    logic out_vld_reg;

    logic out_rdy;
    logic dg_rdy;
    logic st_rdy;
    logic in_rdy;

    assign out_rdy = !out_vld_reg || m_ready;
    assign dg_rdy  = !dg_vld_reg  || out_rdy;
    assign st_rdy  = !st_vld_reg  || dg_rdy;
    assign in_rdy  = !in_vld_reg  || st_rdy;

    assign s_ready = in_rdy;
    assign m_valid = out_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            st_vld_reg  <= 1'b0;
            dg_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (in_rdy)  in_vld_reg  <= s_valid;
            if (st_rdy)  st_vld_reg  <= in_vld_reg;
            if (dg_rdy)  dg_vld_reg  <= st_vld_reg;
            if (out_rdy) out_vld_reg <= dg_vld_reg;
        end
    end

    // ------------------------------------------------------------------
    // input register; the converter target is worked out on the way in
    // ------------------------------------------------------------------
    logic [38:0] tgt_prod;
    logic [11:0] tgt_value;

    assign tgt_prod  = 39'(s_data.adc_sample) * 39'(TGT_RECIP);
    assign tgt_value = TGT_BASE + tgt_prod[TGT_SHIFT +: 12];

    logic        in_mode_reg;
    logic [11:0] in_target_reg;
    logic        in_up_reg;
    logic        in_down_reg;
    logic        in_center_reg;

    always_ff @(posedge aclk) begin
        if (s_valid && in_rdy) begin
            in_mode_reg   <= s_data.mode;
            in_target_reg <= tgt_value;
            in_up_reg     <= s_data.step_up;
            in_down_reg   <= s_data.step_down;
            in_center_reg <= s_data.center;
        end
    end

    // ------------------------------------------------------------------
    // block state
    // ------------------------------------------------------------------
    logic [11:0] width_reg;
    logic [11:0] last_target_reg;
    logic        in_high_reg;
    logic [15:0] phase_cnt_reg;
    logic [15:0] high_ticks_reg;

    logic [11:0] width_next;
    logic [11:0] last_target_next;
    logic        in_high_next;
    logic [15:0] phase_cnt_next;
    logic [15:0] high_ticks_next;

    logic        upd_en;
    assign upd_en = in_vld_reg && st_rdy;

    // pulse train advance
    logic        pc_zero;
    logic        high_start;
    logic        high_done;
    logic [15:0] low_len;
    logic [41:0] latch_prod;
    logic [11:0] latch_ticks;

    assign pc_zero    = (phase_cnt_reg == '0);
    // a low phase that has run out starts a new high phase on this tick
    assign high_start = in_high_reg || pc_zero;
    assign high_done  = high_start && (phase_cnt_reg >= high_ticks_reg);
    // short frame: low phase never below one count
    assign low_len    = (frame_ticks_reg > high_ticks_reg) ?
                        (frame_ticks_reg - high_ticks_reg) : 16'd1;
    // width in microseconds to timer counts for the next frame
    assign latch_prod  = 42'(width_reg) * 42'(TICK_RECIP);
    assign latch_ticks = latch_prod[TICK_SHIFT +: 12];

    // setpoint control
    logic [11:0] w_tgt;
    logic [12:0] up_sum;
    logic [11:0] w_up;
    logic [11:0] w_dn;
    logic [11:0] step_ext;

    assign step_ext = 12'(width_step_reg);
    assign w_tgt    = (in_target_reg != last_target_reg) ? in_target_reg : width_reg;
    assign up_sum   = {1'b0, w_tgt} + {1'b0, step_ext};

    always_comb begin
        w_up = w_tgt;
        if (in_up_reg && (w_tgt < width_max_reg)) begin
            w_up = up_sum[12] ? WIDTH_SAT : up_sum[11:0];
        end
        w_dn = w_up;
        if (in_down_reg && (w_up > width_min_reg)) begin
            w_dn = (w_up > step_ext) ? (w_up - step_ext) : '0;
        end
    end

    always_comb begin
        width_next       = width_reg;
        last_target_next = last_target_reg;
        in_high_next     = in_high_reg;
        phase_cnt_next   = phase_cnt_reg;
        high_ticks_next  = high_ticks_reg;
        if (in_mode_reg == MODE_TICK) begin
            if (high_done) begin
                in_high_next    = 1'b0;
                phase_cnt_next  = low_len - 16'd1;
                high_ticks_next = 16'(latch_ticks);
            end else begin
                in_high_next   = high_start;
                phase_cnt_next = high_start ? (phase_cnt_reg + 16'd1) : (phase_cnt_reg - 16'd1);
            end
        end else begin
            // the last target always ends up equal to the new one
            last_target_next = in_target_reg;
            width_next       = in_center_reg ? width_center_reg : w_dn;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg       <= '0;
            last_target_reg <= '0;
            in_high_reg     <= 1'b1;
            phase_cnt_reg   <= '0;
            high_ticks_reg  <= HIGH_TICKS_RST;
        end else if (upd_en) begin
            width_reg       <= width_next;
            last_target_reg <= last_target_next;
            in_high_reg     <= in_high_next;
            phase_cnt_reg   <= phase_cnt_next;
            high_ticks_reg  <= high_ticks_next;
        end
    end

    // result of the state update
    logic        st_level_reg;
    logic [11:0] st_width_reg;

    always_ff @(posedge aclk) begin
        if (upd_en) begin
            st_level_reg <= in_high_next;
            st_width_reg <= width_next;
        end
    end

    // ------------------------------------------------------------------
    // decimal split, step 1: quotients by 10, 100 and 1000
    // ------------------------------------------------------------------
    logic [23:0] q10_prod;
    logic [22:0] q100_prod;
    logic [24:0] q1000_prod;

    assign q10_prod   = 24'(st_width_reg) * 24'(DIV10_RECIP);
    assign q100_prod  = 23'(st_width_reg) * 23'(DIV100_RECIP);
    assign q1000_prod = 25'(st_width_reg) * 25'(DIV1000_RECIP);

    logic        dg_level_reg;
    logic [11:0] dg_width_reg;
    logic [8:0]  dg_q10_reg;
    logic [5:0]  dg_q100_reg;
    logic [2:0]  dg_q1000_reg;

    always_ff @(posedge aclk) begin
        if (st_vld_reg && dg_rdy) begin
            dg_level_reg <= st_level_reg;
            dg_width_reg <= st_width_reg;
            dg_q10_reg   <= q10_prod[DIV10_SHIFT +: 9];
            dg_q100_reg  <= q100_prod[DIV100_SHIFT +: 6];
            dg_q1000_reg <= q1000_prod[DIV1000_SHIFT +: 3];
        end
    end

    // ------------------------------------------------------------------
    // decimal split, step 2: each digit is a quotient minus ten times the next
    // ------------------------------------------------------------------
    logic [11:0] units_full;
    logic [8:0]  tens_full;
    logic [5:0]  hund_full;

    assign units_full = dg_width_reg - ((12'(dg_q10_reg) << 3) + (12'(dg_q10_reg) << 1));
    assign tens_full  = dg_q10_reg - ((9'(dg_q100_reg) << 3) + (9'(dg_q100_reg) << 1));
    assign hund_full  = dg_q100_reg - ((6'(dg_q1000_reg) << 3) + (6'(dg_q1000_reg) << 1));

    svp_out_t out_reg;

    always_ff @(posedge aclk) begin
        if (dg_vld_reg && out_rdy) begin
            out_reg.pwm_level       <= dg_level_reg;
            out_reg.pulse_width_us  <= dg_width_reg;
            out_reg.digit_thousands <= dg_q1000_reg;
            out_reg.digit_hundreds  <= hund_full[3:0];
            out_reg.digit_tens      <= tens_full[3:0];
            out_reg.digit_units     <= units_full[3:0];
        end
    end

    assign m_data = out_reg;

endmodule

`default_nettype wire

[design/svp_checker.sv]
`default_nettype none

module svp_checker
    import svp_pkg::*;
(
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_valid,
    input wire logic     s_ready,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire svp_out_t m_data
);

    logic [15:0] digit_sum;

    assign digit_sum = 16'(m_data.digit_thousands) * 16'd1000
                     + 16'(m_data.digit_hundreds) * 16'd100
                     + 16'(m_data.digit_tens) * 16'd10
                     + 16'(m_data.digit_units);

    // digits spell out the width
    a_digits_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (digit_sum == 16'(m_data.pulse_width_us)))
        else $error("decimal digits disagree with pulse width");

    a_digits_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.digit_hundreds <= 4'd9) && (m_data.digit_tens <= 4'd9)
                    && (m_data.digit_units <= 4'd9))
        else $error("decimal digit out of range");

    // an empty result side never holds off the input side
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    a_no_result_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result shown right after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

endmodule

bind servo_pulse_setpoint_and_pwm svp_checker u_svp_checker (.*);

`default_nettype wire

[verif/tb_servo_pulse_setpoint_and_pwm.sv]
`timescale 1ns / 100ps

module tb_servo_pulse_setpoint_and_pwm;
    import svp_pkg::*;

    // run shape
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 230;
    localparam int DRAIN_CYCLES    = 8;       // drain margin past the four pipeline stages
    localparam int END_WAIT_LIMIT  = 5000;
    localparam int CYCLE_LIMIT     = 400000;

    // kinds of row in the directed stimulus
    typedef enum bit {
        ROW_ITEM = 1'b0,
        ROW_CFG  = 1'b1
    } row_kind_t;

    typedef struct {
        row_kind_t    kind;
        svp_cfg_idx_t reg_idx;
        logic [15:0]  reg_value;
        svp_in_t      item;
        bit           typed;      // result typed in by hand
        svp_out_t     want;
    } dir_row_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    svp_in_t               s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    svp_out_t              m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [2:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // idle percentages of the current phase
    int unsigned src_idle_pct  = 0;
    int unsigned sink_stall_pct = 0;

    int unsigned fail_cnt  = 0;
    int unsigned cycle_cnt = 0;

    // results still owed by the block, oldest first
    svp_out_t pending_results[$];
    svp_out_t head_result;

    dir_row_t stim_rows[$];

    // predictor copy of the registers
    logic [15:0] frame_len;
    logic [11:0] lim_min;
    logic [11:0] lim_max;
    logic [7:0]  step_size;
    logic [11:0] center_width;

    // predictor copy of the pulse train and setpoint
    logic [11:0] cur_width;
    logic [11:0] prev_target;
    bit          in_high;
    logic [15:0] phase_cnt;
    logic [15:0] high_len;

    servo_pulse_setpoint_and_pwm DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // watchdog on the whole run
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver back-pressure, changed on the falling edge only
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic svp_in_t mk_item(logic md, int adc, bit up, bit dn, bit ctr);
        svp_in_t it;
        it.mode       = md;
        it.adc_sample = 8'(adc);
        it.step_up    = up;
        it.step_down  = dn;
        it.center     = ctr;
        return it;
    endfunction

    function automatic svp_out_t mk_result(bit lvl, int w, int th, int hu, int te, int un);
        svp_out_t r;
        r.pwm_level       = lvl;
        r.pulse_width_us  = 12'(w);
        r.digit_thousands = 3'(th);
        r.digit_hundreds  = 4'(hu);
        r.digit_tens      = 4'(te);
        r.digit_units     = 4'(un);
        return r;
    endfunction

    function automatic dir_row_t item_row(svp_in_t it);
        dir_row_t row;
        row.kind      = ROW_ITEM;
        row.reg_idx   = CFG_FRAME_TICKS;
        row.reg_value = '0;
        row.item      = it;
        row.typed     = 1'b0;
        row.want      = '0;
        return row;
    endfunction

    function automatic dir_row_t typed_row(svp_in_t it, svp_out_t want);
        dir_row_t row;
        row       = item_row(it);
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic dir_row_t cfg_row(svp_cfg_idx_t idx, int value);
        dir_row_t row;
        row           = item_row('0);
        row.kind      = ROW_CFG;
        row.reg_idx   = idx;
        row.reg_value = 16'(value);
        return row;
    endfunction

    // expected result of one accepted item, advancing the predictor state
    function automatic svp_out_t predict_servo_result(svp_in_t it);
        svp_out_t    r;
        int unsigned w;
        int unsigned tgt;
        w = 32'(cur_width);
        if (it.mode == MODE_TICK) begin
            // low phase used up: a new frame starts high
            if (!in_high && phase_cnt == 16'd0) begin
                in_high   = 1'b1;
                phase_cnt = 16'd0;
            end
            // end of the high phase: start the low phase, latch next frame's count
            if (in_high && phase_cnt >= high_len) begin
                phase_cnt = (frame_len > high_len) ? frame_len - high_len : 16'd1;
                high_len  = 16'((w * 9216) / 10000);
                in_high   = 1'b0;
            end
            if (in_high)
                phase_cnt = phase_cnt + 16'd1;
            else
                phase_cnt = phase_cnt - 16'd1;
        end else begin
            // retarget only on a new converter target
            tgt = 500 + (2000 * int'(it.adc_sample)) / 255;
            if (tgt != 32'(prev_target)) begin
                w           = tgt;
                prev_target = 12'(tgt);
            end
            if (it.step_up && w < 32'(lim_max)) begin
                w = w + 32'(step_size);
                if (w > 4095)
                    w = 4095;
            end
            if (it.step_down && w > 32'(lim_min)) begin
                if (w > 32'(step_size))
                    w = w - 32'(step_size);
                else
                    w = 0;
            end
            if (it.center)
                w = 32'(center_width);
            cur_width = 12'(w);
        end
        r.pwm_level       = in_high;
        r.pulse_width_us  = cur_width;
        r.digit_thousands = 3'(cur_width / 1000);
        r.digit_hundreds  = 4'((cur_width / 100) % 10);
        r.digit_tens      = 4'((cur_width / 10) % 10);
        r.digit_units     = 4'(cur_width % 10);
        return r;
    endfunction

    // mostly ticks; control updates mostly hold the phase's converter reading so
    // that center presses keep the width small and frames short
    function automatic svp_in_t random_item(int home_adc);
        if ($urandom_range(99) < 75)
            return mk_item(MODE_TICK, $urandom_range(255), 1'($urandom_range(1)),
                           1'($urandom_range(1)), 1'($urandom_range(1)));
        return mk_item(MODE_CTRL,
                       ($urandom_range(99) < 85) ? home_adc : $urandom_range(255),
                       $urandom_range(99) < 40, $urandom_range(99) < 40,
                       $urandom_range(99) < 35);
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(svp_in_t it, bit typed, svp_out_t want);
        svp_out_t predicted;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        // transfer taken at this edge
        predicted = predict_servo_result(it);
        pending_results.push_back(typed ? want : predicted);
        @(negedge aclk);
    endtask

    // drain the block, then write one register
    task automatic write_reg(svp_cfg_idx_t idx, logic [15:0] value);
        s_valid <= 1'b0;
        do
            @(negedge aclk);
        while (pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_FRAME_TICKS:  frame_len    = value;
            CFG_WIDTH_MIN:    lim_min      = value[11:0];
            CFG_WIDTH_MAX:    lim_max      = value[11:0];
            CFG_WIDTH_STEP:   step_size    = value[7:0];
            CFG_WIDTH_CENTER: center_width = value[11:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    // result checker, sampled on the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing pending");
                fail_cnt++;
            end else begin
                head_result = pending_results.pop_front();
                check_field("pwm_level", 32'(head_result.pwm_level),
                            32'(m_data.pwm_level));
                check_field("pulse_width_us", 32'(head_result.pulse_width_us),
                            32'(m_data.pulse_width_us));
                check_field("digit_thousands", 32'(head_result.digit_thousands),
                            32'(m_data.digit_thousands));
                check_field("digit_hundreds", 32'(head_result.digit_hundreds),
                            32'(m_data.digit_hundreds));
                check_field("digit_tens", 32'(head_result.digit_tens),
                            32'(m_data.digit_tens));
                check_field("digit_units", 32'(head_result.digit_units),
                            32'(m_data.digit_units));
            end
        end
    end

    initial begin
        int unsigned f_val;
        int unsigned min_val;
        int unsigned max_val;
        int unsigned step_val;
        int unsigned ctr_val;
        int          home_adc;

        // predictor at its reset state
        frame_len    = FRAME_TICKS_RST;
        lim_min      = WIDTH_MIN_RST;
        lim_max      = WIDTH_MAX_RST;
        step_size    = WIDTH_STEP_RST;
        center_width = WIDTH_CENTER_RST;
        cur_width    = '0;
        prev_target  = '0;
        in_high      = 1'b1;
        phase_cnt    = '0;
        high_len     = HIGH_TICKS_RST;

        // directed rows, reset registers first
        // first tick after reset is high with zero width
        stim_rows.push_back(typed_row(mk_item(MODE_TICK, 0, 0, 0, 0),
                                      mk_result(1, 0, 0, 0, 0, 0)));
        // lowest and highest converter targets
        stim_rows.push_back(typed_row(mk_item(MODE_CTRL, 0, 0, 0, 0),
                                      mk_result(1, 500, 0, 5, 0, 0)));
        stim_rows.push_back(typed_row(mk_item(MODE_CTRL, 255, 0, 0, 0),
                                      mk_result(1, 2500, 2, 5, 0, 0)));
        // up refused at the max, down allowed, center press
        stim_rows.push_back(typed_row(mk_item(MODE_CTRL, 255, 1, 0, 0),
                                      mk_result(1, 2500, 2, 5, 0, 0)));
        stim_rows.push_back(item_row(mk_item(MODE_CTRL, 255, 0, 1, 0)));
        stim_rows.push_back(typed_row(mk_item(MODE_CTRL, 255, 0, 0, 1),
                                      mk_result(1, 1500, 1, 5, 0, 0)));
        // all presses at once on a new target, then a tick with every other field set
        stim_rows.push_back(item_row(mk_item(MODE_CTRL, 128, 1, 1, 1)));
        stim_rows.push_back(item_row(mk_item(MODE_TICK, 255, 1, 1, 1)));
        // down refused at the min
        stim_rows.push_back(item_row(mk_item(MODE_CTRL, 0, 0, 1, 0)));
        // saturation of a step up at full scale
        stim_rows.push_back(cfg_row(CFG_WIDTH_MAX, 4095));
        stim_rows.push_back(cfg_row(CFG_WIDTH_STEP, 255));
        stim_rows.push_back(cfg_row(CFG_WIDTH_CENTER, 4000));
        stim_rows.push_back(typed_row(mk_item(MODE_CTRL, 0, 0, 0, 1),
                                      mk_result(1, 4000, 4, 0, 0, 0)));
        stim_rows.push_back(typed_row(mk_item(MODE_CTRL, 0, 1, 0, 0),
                                      mk_result(1, 4095, 4, 0, 9, 5)));
        stim_rows.push_back(item_row(mk_item(MODE_CTRL, 0, 1, 0, 0)));
        // saturation of a step down at zero
        stim_rows.push_back(cfg_row(CFG_WIDTH_MIN, 0));
        stim_rows.push_back(cfg_row(CFG_WIDTH_CENTER, 50));
        stim_rows.push_back(item_row(mk_item(MODE_CTRL, 0, 0, 0, 1)));
        stim_rows.push_back(typed_row(mk_item(MODE_CTRL, 0, 0, 1, 0),
                                      mk_result(1, 0, 0, 0, 0, 0)));
        stim_rows.push_back(item_row(mk_item(MODE_CTRL, 0, 0, 1, 0)));
        // one count frame so that the first low phase is the short one
        stim_rows.push_back(cfg_row(CFG_FRAME_TICKS, 1));
        stim_rows.push_back(item_row(mk_item(MODE_TICK, 0, 0, 0, 0)));
        stim_rows.push_back(item_row(mk_item(MODE_TICK, 0, 0, 0, 0)));

        // synchronous reset held, then released at a falling edge
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_CFG)
                write_reg(stim_rows[i].reg_idx, stim_rows[i].reg_value);
            else
                send_item(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].want);
        end

        // random phases; the first carries the lowest register settings and the last
        // the highest, the others mostly small frames and small center widths so the
        // pulse train runs through many frames
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    f_val = 1; min_val = 0; max_val = 0; step_val = 0; ctr_val = 0;
                end
                NUM_PHASES - 1: begin
                    f_val = 65535; min_val = 4095; max_val = 4095;
                    step_val = 255; ctr_val = 4095;
                end
                default: begin
                    f_val    = (p == 5) ? $urandom_range(1, 65535) : $urandom_range(1, 400);
                    min_val  = $urandom_range(0, 4095);
                    max_val  = $urandom_range(0, 4095);
                    step_val = $urandom_range(0, 255);
                    ctr_val  = (p == 6) ? $urandom_range(0, 4095) : $urandom_range(0, 150);
                end
            endcase
            write_reg(CFG_FRAME_TICKS, 16'(f_val));
            write_reg(CFG_WIDTH_MIN, 16'(min_val));
            write_reg(CFG_WIDTH_MAX, 16'(max_val));
            write_reg(CFG_WIDTH_STEP, 16'(step_val));
            write_reg(CFG_WIDTH_CENTER, 16'(ctr_val));

            // idle pattern: none, sender, receiver, both
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 52; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 52; end
                default: begin src_idle_pct = 21; sink_stall_pct = 21; end
            endcase

            home_adc = $urandom_range(255);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_item(random_item(home_adc), 1'b0, '0);
        end

        // all stimulus taken: wait for the last results, then past the latency
        s_valid <= 1'b0;
        for (int n = 0; n < END_WAIT_LIMIT && pending_results.size() != 0; n++)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d results never delivered", pending_results.size());
            fail_cnt++;
        end

        if (fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
design/svp_pkg.sv
design/servo_pulse_setpoint_and_pwm.sv
design/svp_checker.sv
verif/tb_servo_pulse_setpoint_and_pwm.sv
